@@ rtl/core/t4t_pkg.sv @@
// Shared types and constants for the Type 4 Tag APDU responder.
// Holds the request and beat payload structs, command codes, status words
// and the fixed capability-container image. No dependencies.
package t4t_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  apdu_length;
        logic [7:0]  instruction;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [7:0]  length_byte;
        logic [55:0] body;
        logic [8:0]  load_address;
        logic [7:0]  load_data;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
        logic [7:0] byte_six;
        logic [7:0] byte_seven;
        logic [3:0] byte_count;
        logic       last_beat;
    } rsp_item_t;

    // Request opcodes
    localparam logic [1:0] OP_APDU    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_SESSION = 2'd2;

    // Selected file codes
    localparam logic [1:0] FILE_NONE = 2'd0;
    localparam logic [1:0] FILE_CC   = 2'd1;
    localparam logic [1:0] FILE_NDEF = 2'd2;

    // Instruction bytes
    localparam logic [7:0] INS_SELECT = 8'hA4;
    localparam logic [7:0] INS_READ   = 8'hB0;
    localparam logic [7:0] INS_UPDATE = 8'hD6;

    localparam logic [7:0] P1_BY_AID = 8'h04;
    localparam logic [7:0] P1_BY_FID = 8'h00;
    localparam logic [7:0] LC_AID    = 8'd7;
    localparam logic [7:0] LC_FID    = 8'd2;

    localparam logic [55:0] NDEF_AID = 56'hD2_76_00_00_85_01_01;
    localparam logic [15:0] FID_CC   = 16'hE103;
    localparam logic [15:0] FID_NDEF = 16'hE104;

    // Status words
    localparam logic [15:0] SW_OK        = 16'h9000;
    localparam logic [15:0] SW_NOT_FOUND = 16'h6A82;
    localparam logic [15:0] SW_DENIED    = 16'h6982;

    localparam logic [16:0] CC_LEN   = 17'd15;
    localparam logic [16:0] MAX_DATA = 17'd253;
    localparam logic [7:0]  LE_FULL  = 8'd255;

    function automatic logic [7:0] cc_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h0F;
            4'd2:    b = 8'h20;
            4'd3:    b = 8'h00;
            4'd4:    b = 8'hFF;
            4'd5:    b = 8'h00;
            4'd6:    b = 8'hFF;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h06;
            4'd9:    b = 8'hE1;
            4'd10:   b = 8'h04;
            4'd11:   b = 8'h04;
            4'd12:   b = 8'h00;
            4'd13:   b = 8'h00;
            4'd14:   b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/type4_tag_apdu_responder_unit.sv @@
// Type 4 Tag APDU responder: decodes one request per item, streams the response.
// Throughput: one response byte per cycle while the receiver does not stall; a
// response of n data bytes plus the status word holds off the next request until
// it is fully packed. Load and session requests produce no response.
// Reset clears selection, length register and sequencer; the store is not cleared.
module type4_tag_apdu_responder_unit #(
    parameter int NDEF_DEPTH = 512,
    parameter int OUT_LANES  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  t4t_pkg::cmd_item_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output t4t_pkg::rsp_item_t rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [9:0]        cfg_data
);

    import t4t_pkg::*;

    localparam int AW    = $clog2(NDEF_DEPTH);
    localparam int FLW   = $clog2(NDEF_DEPTH + 1);
    localparam int LANES = (OUT_LANES > 8) ? 8 : ((OUT_LANES < 1) ? 1 : OUT_LANES);
    localparam logic [2:0] LAST_LANE = 3'(LANES - 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } seq_state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    seq_state_t  state_reg, state_next;
    logic [9:0]  flen_cfg_reg, flen_cfg_next;
    logic [1:0]  sel_reg, sel_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  n_reg, n_next;
    logic [15:0] sw_reg, sw_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic        src_ndef_reg, src_ndef_next;

    // byte stage: one response byte waiting for the packer
    logic        b_valid_reg, b_valid_next;
    logic        b_last_reg, b_last_next;
    logic        b_ram_reg, b_ram_next;
    logic [7:0]  b_byte_reg, b_byte_next;

    // packer: partial beat
    logic [2:0]  pk_cnt_reg, pk_cnt_next;
    logic [7:0]  pk_reg [0:7];
    logic [7:0]  pk_next [0:7];

    // output register
    logic        out_valid_reg, out_valid_next;
    rsp_item_t   out_reg, out_next;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic busy;
    logic cmd_acc;
    logic completes, out_free, consume, issue;
    logic [7:0] cur_byte;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_rdata;

    // Accept a new request only once the previous response is fully packed;
    // the last beat may still wait in the output register.
    assign busy      = (state_reg == ST_ISSUE) || b_valid_reg;
    assign cmd_stall = busy;
    assign cmd_acc   = cmd_valid && !busy;
    assign cfg_ready = !busy;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // ------------------------------------------------------------------
    // NDEF store
    // ------------------------------------------------------------------
    assign ram_we    = cmd_acc && (cmd.opcode == OP_LOAD)
                       && (32'(cmd.load_address) < NDEF_DEPTH);
    assign ram_waddr = AW'(cmd.load_address);
    assign ram_re    = issue && src_ndef_reg && (pos_reg < n_reg);

    t4t_ram #(
        .WIDTH (8),
        .DEPTH (NDEF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (cmd.load_data),
        .rd_en   (ram_re),
        .rd_addr (ptr_reg),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Command decode (at acceptance)
    // ------------------------------------------------------------------
    logic [7:0]     lc, le;
    logic [15:0]    offset;
    logic [FLW-1:0] flen_sat;
    logic [16:0]    file_len, avail, n_full;
    logic           in_file, drop;
    logic [1:0]     dec_sel;
    logic [15:0]    dec_sw;
    logic           dec_read;
    logic [15:0]    fid;

    always_comb
    begin
        lc       = (cmd.apdu_length > 6'd4) ? cmd.length_byte : 8'd0;
        le       = (lc == 8'd0) ? LE_FULL : lc;
        offset   = {cmd.param_one, cmd.param_two};
        fid      = cmd.body[55:40];
        flen_sat = (32'(flen_cfg_reg) > NDEF_DEPTH) ? FLW'(NDEF_DEPTH) : FLW'(flen_cfg_reg);
        file_len = (sel_reg == FILE_CC) ? CC_LEN : 17'(flen_sat);
        in_file  = (file_len != 17'd0) && (17'(offset) < file_len);
        avail    = file_len - 17'(offset);
        n_full   = (17'(le) < avail) ? 17'(le) : avail;
        drop     = in_file && (n_full > MAX_DATA);

        dec_sel  = sel_reg;
        dec_sw   = SW_OK;
        dec_read = 1'b0;
        if (cmd.apdu_length < 6'd4)
        begin
            dec_sw = SW_OK;
        end
        else
        begin
            case (cmd.instruction)
                INS_SELECT:
                begin
                    if (cmd.param_one == P1_BY_AID && lc == LC_AID && cmd.body == NDEF_AID)
                    begin
                        dec_sel = FILE_NONE;
                    end
                    else if (cmd.param_one == P1_BY_FID && lc == LC_FID)
                    begin
                        if (fid == FID_CC)
                        begin
                            dec_sel = FILE_CC;
                        end
                        else if (fid == FID_NDEF)
                        begin
                            dec_sel = FILE_NDEF;
                        end
                        else
                        begin
                            dec_sw = SW_NOT_FOUND;
                        end
                    end
                end
                INS_READ:
                begin
                    if (sel_reg == FILE_CC || sel_reg == FILE_NDEF)
                    begin
                        dec_read = 1'b1;
                    end
                    else
                    begin
                        dec_sw = SW_NOT_FOUND;
                    end
                end
                INS_UPDATE: dec_sw = SW_DENIED;
                default:    dec_sw = SW_OK;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Byte sequencer, byte stage, packer and output register
    // ------------------------------------------------------------------
    assign cur_byte  = b_ram_reg ? ram_rdata : b_byte_reg;
    assign completes = b_last_reg || (pk_cnt_reg == LAST_LANE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign consume   = b_valid_reg && (!completes || out_free);
    // Issue the next byte only when the byte stage frees up, so a RAM read
    // result is never overwritten before the packer takes it.
    assign issue     = (state_reg == ST_ISSUE) && (!b_valid_reg || consume);

    always_comb
    begin
        logic [7:0] lane [0:7];

        state_next    = state_reg;
        flen_cfg_next = flen_cfg_reg;
        sel_next      = sel_reg;
        pos_next      = pos_reg;
        n_next        = n_reg;
        sw_next       = sw_reg;
        ptr_next      = ptr_reg;
        src_ndef_next = src_ndef_reg;
        b_valid_next  = b_valid_reg;
        b_last_next   = b_last_reg;
        b_ram_next    = b_ram_reg;
        b_byte_next   = b_byte_reg;
        pk_cnt_next   = pk_cnt_reg;
        pk_next       = pk_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next      = out_reg;

        if (cfg_valid && cfg_ready)
        begin
            flen_cfg_next = cfg_data;
        end

        // start a request
        if (cmd_acc)
        begin
            case (cmd.opcode)
                OP_APDU:
                begin
                    sel_next = dec_sel;
                    if (!(dec_read && drop))
                    begin
                        state_next    = ST_ISSUE;
                        pos_next      = 8'd0;
                        n_next        = (dec_read && in_file) ? n_full[7:0] : 8'd0;
                        sw_next       = dec_sw;
                        ptr_next      = AW'(offset);
                        src_ndef_next = (sel_reg == FILE_NDEF);
                    end
                end
                OP_SESSION: sel_next = FILE_NONE;
                default:    sel_next = sel_reg;
            endcase
        end

        // advance the sequencer by one byte
        if (issue)
        begin
            b_valid_next = 1'b1;
            b_last_next  = 1'b0;
            b_ram_next   = 1'b0;
            pos_next     = pos_reg + 8'd1;
            if (pos_reg < n_reg)
            begin
                b_ram_next  = src_ndef_reg;
                b_byte_next = cc_byte(ptr_reg[3:0]);
                ptr_next    = ptr_reg + AW'(1);
            end
            else if (pos_reg == n_reg)
            begin
                b_byte_next = sw_reg[15:8];
            end
            else
            begin
                b_byte_next = sw_reg[7:0];
                b_last_next = 1'b1;
                state_next  = ST_IDLE;
            end
        end
        else if (consume)
        begin
            b_valid_next = 1'b0;
        end

        // pack the byte; push a finished beat to the output register
        for (int j = 0; j < 8; j++)
        begin
            if (3'(j) < pk_cnt_reg)
            begin
                lane[j] = pk_reg[j];
            end
            else if (3'(j) == pk_cnt_reg)
            begin
                lane[j] = cur_byte;
            end
            else
            begin
                lane[j] = 8'd0;
            end
        end

        if (consume)
        begin
            if (completes)
            begin
                pk_cnt_next         = 3'd0;
                out_valid_next      = 1'b1;
                out_next.byte_zero  = lane[0];
                out_next.byte_one   = lane[1];
                out_next.byte_two   = lane[2];
                out_next.byte_three = lane[3];
                out_next.byte_four  = lane[4];
                out_next.byte_five  = lane[5];
                out_next.byte_six   = lane[6];
                out_next.byte_seven = lane[7];
                out_next.byte_count = 4'(pk_cnt_reg) + 4'd1;
                out_next.last_beat  = b_last_reg;
            end
            else
            begin
                pk_next[pk_cnt_reg] = cur_byte;
                pk_cnt_next         = pk_cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flen_cfg_reg  <= 10'd0;
            sel_reg       <= FILE_NONE;
            b_valid_reg   <= 1'b0;
            pk_cnt_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flen_cfg_reg  <= flen_cfg_next;
            sel_reg       <= sel_next;
            b_valid_reg   <= b_valid_next;
            pk_cnt_reg    <= pk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        n_reg        <= n_next;
        sw_reg       <= sw_next;
        ptr_reg      <= ptr_next;
        src_ndef_reg <= src_ndef_next;
        b_last_reg   <= b_last_next;
        b_ram_reg    <= b_ram_next;
        b_byte_reg   <= b_byte_next;
        pk_reg       <= pk_next;
        out_reg      <= out_next;
    end

`ifndef SYNTHESIS
    // A request is taken only with the packer empty.
    a_idle_pack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |-> pk_cnt_reg == 3'd0)
        else $error("request accepted with a partial beat pending");

    // The sequencer never runs past the second status byte.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> pos_reg <= n_reg + 8'd1)
        else $error("sequencer position past end of response");

    // Every beat but the last is full.
    a_full_beats: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last_beat |-> rsp.byte_count == 4'(LANES))
        else $error("short beat before end of response");

    // Beat byte count stays in range.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.byte_count != 4'd0 && rsp.byte_count <= 4'(LANES))
        else $error("beat byte count out of range");
`endif

endmodule

@@ rtl/core/t4t_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is enabled. No dependencies.
module t4t_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ bench/type4_tag_apdu_responder_unit_test.sv @@
// Self-checking bench for type4_tag_apdu_responder_unit: a directed table, then random requests.
// Depends on t4t_pkg and the responder RTL; every response beat is predicted or typed in here
// and compared field by field.
module type4_tag_apdu_responder_unit_test;
    import t4t_pkg::*;

    // Opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STORE_DEPTH = 512;
    localparam int MAX_READ    = 253;
    // Store bytes loaded up front: the low end from address 0, the high end up to the top
    localparam int FILL_LOW    = 48;
    localparam int FILL_HIGH   = 8;
    // Requests counted per random phase
    localparam int PHASE_ITEMS = 10;
    // Cycles to let pass once nothing is expected, covering silent requests still in flight
    localparam int SETTLE_CYCLES = 64;
    // Long receiver hold-off, long enough to back the block up into its request side
    localparam int LONG_HOLD = 400;

    // Capability container, byte 0 in the top byte
    localparam logic [119:0] CC_FILE = 120'h000F_2000_FF00_FF04_06E1_0404_0000_FF;

    typedef struct {
        bit          set_len;   // drain and rewrite the file length before this request
        logic [9:0]  len;
        cmd_item_t   item;
        bit          fixed;     // expectation typed in below instead of predicted
        logic [15:0] sw;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    cmd_item_t  cmd;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_item_t  rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [9:0] cfg_data;

    // Predictor state: selection, file length register, NDEF store copy
    logic [1:0] model_sel;
    logic [9:0] model_len;
    logic [7:0] model_store [0:STORE_DEPTH-1];

    rsp_item_t  pending_beats [$];
    int         failures;
    bit         hold_request;
    bit         calm;

    type4_tag_apdu_responder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Build one request; the load fields get random filler
    function automatic cmd_item_t apdu_req(input logic [1:0] op, input logic [5:0] alen,
                                           input logic [7:0] ins, input logic [7:0] p1,
                                           input logic [7:0] p2, input logic [7:0] lb,
                                           input logic [55:0] body);
        cmd_item_t c;
        c.opcode       = op;
        c.apdu_length  = alen;
        c.instruction  = ins;
        c.param_one    = p1;
        c.param_two    = p2;
        c.length_byte  = lb;
        c.body         = body;
        c.load_address = 9'($urandom_range(0, STORE_DEPTH - 1));
        c.load_data    = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Work out the response beats a request causes and advance the predictor state.
    // Load and session requests only touch state; an oversize read yields no beats.
    function automatic void predict_response(input cmd_item_t c, output rsp_item_t beats [$]);
        logic [7:0]  lc;
        logic [15:0] sw;
        logic [63:0] lanes;
        logic [7:0]  resp [$];
        int          offset;
        int          le;
        int          flen;
        int          n;
        int          pos;
        int          cnt;
        int          i;
        beats = {};
        if (c.opcode == OP_LOAD) begin
            model_store[c.load_address] = c.load_data;
            return;
        end
        if (c.opcode == OP_SESSION) begin
            model_sel = FILE_NONE;
            return;
        end
        if (c.opcode != OP_APDU)
            return;

        // Lc/Le only exists when a fifth byte arrived
        lc = (c.apdu_length > 6'd4) ? c.length_byte : 8'd0;
        sw = SW_OK;
        if (c.apdu_length >= 6'd4) begin
            if (c.instruction == INS_SELECT) begin
                if (c.param_one == P1_BY_AID && lc == LC_AID && c.body == NDEF_AID)
                    model_sel = FILE_NONE;
                else if (c.param_one == P1_BY_FID && lc == LC_FID) begin
                    if (c.body[55:40] == FID_CC)
                        model_sel = FILE_CC;
                    else if (c.body[55:40] == FID_NDEF)
                        model_sel = FILE_NDEF;
                    else
                        sw = SW_NOT_FOUND;
                end
            end else if (c.instruction == INS_READ) begin
                offset = int'({c.param_one, c.param_two});
                le     = (lc == 8'd0) ? 255 : int'(lc);
                flen   = 0;
                if (model_sel == FILE_CC)
                    flen = 15;
                else if (model_sel == FILE_NDEF)
                    flen = (int'(model_len) > STORE_DEPTH) ? STORE_DEPTH : int'(model_len);
                else
                    sw = SW_NOT_FOUND;
                if (offset < flen) begin
                    n = (le < flen - offset) ? le : flen - offset;
                    if (n > MAX_READ)
                        return;
                    for (i = 0; i < n; i++)
                        resp.push_back(model_sel == FILE_CC ? CC_FILE[119 - 8 * (offset + i) -: 8]
                                                            : model_store[offset + i]);
                end
            end else if (c.instruction == INS_UPDATE) begin
                sw = SW_DENIED;
            end
        end
        resp.push_back(sw[15:8]);
        resp.push_back(sw[7:0]);

        // Pack eight bytes per beat, unused lanes zero
        pos = 0;
        while (pos < resp.size()) begin
            cnt   = (resp.size() - pos > 8) ? 8 : resp.size() - pos;
            lanes = '0;
            for (i = 0; i < cnt; i++)
                lanes[63 - 8 * i -: 8] = resp[pos + i];
            pos += cnt;
            beats.push_back(rsp_item_t'({lanes, 4'(cnt), pos >= resp.size()}));
        end
    endfunction

    // Mostly well-formed traffic: reads near the files, selects, AID selects with the
    // odd corrupted bit, updates, sessions, loads; the rest is raw noise.
    function automatic cmd_item_t random_request();
        cmd_item_t   c;
        logic [63:0] r;
        logic [15:0] off;
        int          pick;
        r    = {$urandom, $urandom};
        c    = apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, r[55:0]);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            off = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20))
                                              : 16'($urandom_range(0, 530));
            c.param_one = off[15:8];
            c.param_two = off[7:0];
            case ($urandom_range(0, 3))
                0:       c.length_byte = 8'd0;
                1:       c.length_byte = 8'($urandom_range(200, 255));
                default: c.length_byte = 8'($urandom_range(1, 40));
            endcase
            if ($urandom_range(0, 4) == 0)
                c.apdu_length = 6'd4;
        end else if (pick < 60) begin
            c.instruction = INS_SELECT;
            c.param_one   = P1_BY_FID;
            c.length_byte = LC_FID;
            c.apdu_length = 6'd7;
            case ($urandom_range(0, 4))
                0, 1:    c.body[55:40] = FID_CC;
                2, 3:    c.body[55:40] = FID_NDEF;
                default: c.body[55:40] = r[63:48];
            endcase
        end else if (pick < 68) begin
            c.instruction = INS_SELECT;
            c.param_one   = P1_BY_AID;
            c.length_byte = LC_AID;
            c.apdu_length = 6'd12;
            c.body        = NDEF_AID;
            if ($urandom_range(0, 2) == 0)
                c.body[$urandom_range(0, 55)] ^= 1'b1;
        end else if (pick < 76) begin
            c.instruction = INS_UPDATE;
            c.apdu_length = 6'($urandom_range(4, 60));
        end else if (pick < 82) begin
            c.opcode = OP_SESSION;
        end else if (pick < 90) begin
            c.opcode = OP_LOAD;
        end else begin
            c.opcode      = 2'($urandom_range(0, 3));
            c.apdu_length = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 3))
                0:       c.instruction = INS_SELECT;
                1:       c.instruction = INS_READ;
                2:       c.instruction = INS_UPDATE;
                default: c.instruction = 8'($urandom_range(0, 255));
            endcase
            c.param_one   = 8'($urandom_range(0, 255));
            c.param_two   = 8'($urandom_range(0, 255));
            c.length_byte = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Offer one request and hold it until accepted; leave valid high so a
    // back-to-back request needs no extra edge. Queue its expected beats.
    task automatic send_request(input cmd_item_t c, input bit fixed, input logic [15:0] sw);
        rsp_item_t beats [$];
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_response(c, beats);
        if (fixed)
            pending_beats.push_back(rsp_item_t'({sw, 48'd0, 4'd2, 1'b1}));
        else
            foreach (beats[k])
                pending_beats.push_back(beats[k]);
    endtask

    // Now and then drop valid for a random burst and scramble the idle payload
    task automatic sender_gap();
        logic [63:0] junk;
        if (calm || $urandom_range(0, 5) != 0)
            return;
        junk      = {$urandom, $urandom};
        cmd_valid <= 1'b0;
        cmd       <= cmd_item_t'({junk, junk[48:0]});
        repeat ($urandom_range(1, 17)) @(posedge clk);
    endtask

    // Stop offering, wait for every expected beat, then let silent work finish
    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_beats.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_file_length(input logic [9:0] len);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_len = len;
    endtask

    // Response side: check each accepted beat against the oldest expectation,
    // then pick the stall for the next cycle.
    initial
    begin : response_monitor
        rsp_item_t want;
        int        burst;
        int        long_hold;
        burst     = 0;
        long_hold = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall) begin
                if (pending_beats.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected response beat: got %h", rsp);
                end else begin
                    want = pending_beats.pop_front();
                    if (rsp.byte_zero  !== want.byte_zero  || rsp.byte_one   !== want.byte_one   ||
                        rsp.byte_two   !== want.byte_two   || rsp.byte_three !== want.byte_three ||
                        rsp.byte_four  !== want.byte_four  || rsp.byte_five  !== want.byte_five  ||
                        rsp.byte_six   !== want.byte_six   || rsp.byte_seven !== want.byte_seven ||
                        rsp.byte_count !== want.byte_count || rsp.last_beat  !== want.last_beat) begin
                        failures++;
                        if (failures <= 10)
                            $display("response beat mismatch: expected %h, got %h", want, rsp);
                    end
                end
            end
            // Take a long hold-off when asked, else random stall bursts
            if (hold_request) begin
                hold_request = 1'b0;
                long_hold    = LONG_HOLD;
            end
            if (long_hold > 0) begin
                long_hold--;
                rsp_stall <= 1'b1;
            end else if (calm) begin
                rsp_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 16);
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Request side: reset, fill the store, walk the directed table, then random phases
    initial
    begin : request_driver
        plan_row_t  plan [$];
        logic [9:0] phase_len [0:4];
        cmd_item_t  c;
        logic [7:0] fill_byte;
        int         sent;
        int         a;
        int         p;

        failures     = 0;
        hold_request = 1'b0;
        calm         = 1'b0;
        model_sel    = FILE_NONE;
        model_len    = 10'd0;
        rst_n        <= 1'b0;
        cmd_valid    <= 1'b0;
        cmd          <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typed-in rows hold answers that follow straight from the request; the
        // rest go through the predictor. Selection is still clear after the fill.
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h10, '0),
                         1'b1, SW_NOT_FOUND});                 // read with nothing selected
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd0, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b1, SW_OK});                        // empty request
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1),
                         1'b1, SW_OK});                        // too short
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd60, INS_UPDATE, 8'h00, 8'h00, 8'h10, '0),
                         1'b1, SW_DENIED});                    // update refused
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd4, 8'h00, 8'h00, 8'h00, 8'h00, '0),
                         1'b1, SW_OK});                        // unknown instruction
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1),
                         1'b1, SW_OK});                        // all ones
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd7, INS_SELECT, P1_BY_FID, 8'h00, LC_FID,
                                               {FID_CC, 40'd0}), 1'b1, SW_OK});
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd4, INS_READ, 8'h00, 8'h00, 8'hFF, '1),
                         1'b0, SW_OK});                        // Le absent: whole CC
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h0E, 8'd5, '0),
                         1'b0, SW_OK});                        // clipped at CC end
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h0F, 8'd1, '0),
                         1'b1, SW_OK});                        // at CC end
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'hFF, 8'hFF, 8'hFF, '0),
                         1'b1, SW_OK});                        // highest offset
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd7, INS_SELECT, P1_BY_FID, 8'h00, LC_FID,
                                               {16'h1234, 40'd0}), 1'b1, SW_NOT_FOUND});
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h03, 8'd1, '0),
                         1'b0, SW_OK});                        // CC selection kept
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd12, INS_SELECT, P1_BY_AID, 8'h00, LC_AID,
                                               NDEF_AID), 1'b1, SW_OK});   // AID clears selection
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b1, SW_NOT_FOUND});
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd4, INS_SELECT, P1_BY_FID, 8'h00, LC_FID,
                                               {FID_NDEF, 40'd0}), 1'b1, SW_OK});  // Lc absent
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd12, INS_SELECT, P1_BY_AID, 8'h00, 8'd6,
                                               NDEF_AID), 1'b1, SW_OK});   // wrong Lc
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b1, SW_NOT_FOUND});
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_SELECT, P1_BY_FID, 8'h00, LC_FID,
                                               {FID_NDEF, 40'd0}), 1'b1, SW_OK});  // ID from body
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b1, SW_OK});                        // empty NDEF file
        plan.push_back('{1'b1, 10'd512, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b0, SW_OK});                        // oversize read, silent
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00,
                                               8'(FILL_LOW), '0),
                         1'b0, SW_OK});                        // whole low fill, seven beats
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h01, 8'hFE, 8'h00, '0),
                         1'b0, SW_OK});
        plan.push_back('{1'b1, 10'd1023, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h01, 8'hFF, 8'd1, '0),
                         1'b0, SW_OK});                        // length saturates at the depth
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h02, 8'h00, 8'h00, '0),
                         1'b1, SW_OK});
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_SESSION, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b0, SW_OK});                        // new session, no response
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_APDU, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b1, SW_NOT_FOUND});
        plan.push_back('{1'b0, 10'd0, apdu_req(OP_UNUSED, 6'd5, INS_READ, 8'h00, 8'h00, 8'h00, '0),
                         1'b0, SW_OK});                        // ignored opcode

        // Fill both ends of the store; every read below stays inside the filled bytes
        for (a = 0; a < FILL_LOW + FILL_HIGH; a++) begin
            fill_byte = 8'($urandom_range(0, 255));
            c = apdu_req(OP_LOAD, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, '0);
            c.load_address = (a < FILL_LOW) ? 9'(a)
                                            : 9'(STORE_DEPTH - FILL_LOW - FILL_HIGH + a);
            c.load_data    = fill_byte;
            sender_gap();
            send_request(c, 1'b0, SW_OK);
        end

        foreach (plan[r]) begin
            if (plan[r].set_len) begin
                settle();
                write_file_length(plan[r].len);
            end else begin
                sender_gap();
            end
            send_request(plan[r].item, plan[r].fixed, plan[r].sw);
        end

        // Random phases, each under its own file length within the low fill; hold the
        // receiver off in the second, run the last with no idling at all
        phase_len[0] = 10'(FILL_LOW);
        phase_len[1] = 10'($urandom_range(1, FILL_LOW - 1));
        phase_len[2] = 10'd0;
        phase_len[3] = 10'd1;
        phase_len[4] = 10'($urandom_range(16, FILL_LOW));
        for (p = 0; p < 5; p++) begin
            settle();
            write_file_length(phase_len[p]);
            if (p == 1)
                hold_request = 1'b1;
            if (p == 4)
                calm = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                c = random_request();
                if (c.opcode != OP_UNUSED)
                    sent++;
                sender_gap();
                send_request(c, 1'b0, SW_OK);
            end
        end

        settle();
        failures += pending_beats.size();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run well past the slowest legal finish
    initial
    begin : run_limit
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
